// ----- src/pbrst_pkg.sv -----
// ---------------------------------------------------------------------------
// pbrst_pkg - shared types and codes for the per-band rate sorted table
// Words on both channels, the stored entry, cell shift codes and band control.
// ---------------------------------------------------------------------------
package pbrst_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_GET    = 2'd2;
  localparam logic [1:0] KIND_BEST   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // what a cell loads on the next edge
  localparam logic [2:0] CELL_HOLD = 3'd0;
  localparam logic [2:0] CELL_NEW  = 3'd1;
  localparam logic [2:0] CELL_PREV = 3'd2;
  localparam logic [2:0] CELL_NEXT = 3'd3;
  localparam logic [2:0] CELL_HEAD = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         band;
    logic [15:0]        node_id;
    logic [15:0]        dest_id;
    logic [2:0]         direction;
    logic signed [15:0] tx_power;
    logic [31:0]        rate;
    logic [3:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        out_node_id;
    logic [15:0]        out_dest_id;
    logic [2:0]         out_direction;
    logic signed [15:0] out_tx_power;
    logic [31:0]        out_rate;
    logic [2:0]         best_band;
    logic [7:0]         removed_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        node_id;
    logic [15:0]        dest_id;
    logic [2:0]         direction;
    logic signed [15:0] tx_power;
    logic [31:0]        rate;
  } entry_t;

  typedef struct packed {
    logic start;  // snapshot lengths, clear per-band best
    logic ins;    // insert cycle
    logic rot;    // plain rotation step (get, best)
    logic rm;     // compacting step (remove)
    logic best;   // track first match at the head
    logic shift;  // move per-band best towards band 0
  } band_ctl_t;

endpackage

// ----- src/pbrst_cell.sv -----
// ---------------------------------------------------------------------------
// pbrst_cell - one list slot
// Holds one entry and loads from a neighbour, the head or the new word.
// ---------------------------------------------------------------------------
module pbrst_cell (
  input  logic            clk_i,
  input  logic [2:0]      op_i,
  input  pbrst_pkg::entry_t new_i,
  input  pbrst_pkg::entry_t prev_i,
  input  pbrst_pkg::entry_t next_i,
  input  pbrst_pkg::entry_t head_i,
  output pbrst_pkg::entry_t entry_o
);
  import pbrst_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    case (op_i)
      CELL_NEW:  entry_d = new_i;
      CELL_PREV: entry_d = prev_i;
      CELL_NEXT: entry_d = next_i;
      CELL_HEAD: entry_d = head_i;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- src/pbrst_band.sv -----
// ---------------------------------------------------------------------------
// pbrst_band - sorted list of one band as a chain of cells
// Parallel insert, rotation for reads, rotation with compaction for remove.
// ---------------------------------------------------------------------------
module pbrst_band #(
  parameter int LIST_DEPTH = 16,
  parameter int LW         = $clog2(LIST_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbrst_pkg::band_ctl_t ctl_i,
  input  logic                sel_i,
  input  logic [LW-1:0]       step_i,
  input  pbrst_pkg::entry_t   new_i,
  input  logic [15:0]         node_i,
  input  logic                bf_next_i,
  input  logic [31:0]         brate_next_i,
  output pbrst_pkg::entry_t   head_o,
  output logic [LW-1:0]       len_o,
  output logic                full_o,
  output logic                drop_o,
  output logic                bf_o,
  output logic [31:0]         brate_o
);
  import pbrst_pkg::*;

  entry_t        ent [LIST_DEPTH];
  logic          lower [LIST_DEPTH];
  logic [2:0]    op [LIST_DEPTH];
  logic [LW-1:0] len_q, len_d, scan_len_q, tail;
  logic          bf_q, bf_d;
  logic [31:0]   brate_q, brate_d;
  logic          active, match, rm_act, ins_act;

  assign full_o  = (len_q == LW'(LIST_DEPTH));
  assign active  = (step_i < scan_len_q);
  assign match   = (ent[0].node_id == node_i);
  assign rm_act  = ctl_i.rm && active;
  assign ins_act = ctl_i.ins && sel_i && !full_o;
  assign tail    = len_q - 1'b1;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;

    assign lower[i] = (LW'(i) < len_q) && (ent[i].rate < new_i.rate);

    if (i > 0) begin : g_prev
      assign prev_e = ent[i-1];
    end else begin : g_noprev
      assign prev_e = new_i;
    end
    if (i < LIST_DEPTH - 1) begin : g_next
      assign next_e = ent[i+1];
    end else begin : g_wrap
      assign next_e = ent[0];
    end

    always_comb begin
      op[i] = CELL_HOLD;
      if (ins_act) begin
        if (i > 0 && lower[(i > 0) ? i-1 : 0]) begin
          op[i] = CELL_PREV;
        end else if (lower[i] || LW'(i) == len_q) begin
          op[i] = CELL_NEW;
        end
      end else if (ctl_i.rot) begin
        op[i] = (i == LIST_DEPTH - 1) ? CELL_HEAD : CELL_NEXT;
      end else if (rm_act) begin
        // kept head goes to the live tail, dropped head is overwritten
        if (LW'(i) < tail) begin
          op[i] = CELL_NEXT;
        end else if (LW'(i) == tail && !match) begin
          op[i] = CELL_HEAD;
        end
      end
    end

    pbrst_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op[i]),
      .new_i   (new_i),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .head_i  (ent[0]),
      .entry_o (ent[i])
    );
  end

  always_comb begin
    len_d = len_q;
    if (ins_act) begin
      len_d = len_q + 1'b1;
    end else if (rm_act && match) begin
      len_d = len_q - 1'b1;
    end
  end

  always_comb begin
    bf_d    = bf_q;
    brate_d = brate_q;
    if (ctl_i.start) begin
      bf_d    = 1'b0;
      brate_d = '0;
    end else if (ctl_i.best && active && match && !bf_q) begin
      bf_d    = 1'b1;
      brate_d = ent[0].rate;
    end else if (ctl_i.shift) begin
      bf_d    = bf_next_i;
      brate_d = brate_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      scan_len_q <= '0;
      bf_q       <= 1'b0;
    end else begin
      len_q <= len_d;
      bf_q  <= bf_d;
      if (ctl_i.start) begin
        scan_len_q <= len_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    brate_q <= brate_d;
  end

  assign head_o  = ent[0];
  assign len_o   = len_q;
  assign drop_o  = rm_act && match;
  assign bf_o    = bf_q;
  assign brate_o = brate_q;

endmodule

// ----- src/per_band_rate_sorted_table.sv -----
// ---------------------------------------------------------------------------
// per_band_rate_sorted_table - per-band lists of node entries sorted by rate
// One request word in, one result word out, valid/ready on both sides.
// ---------------------------------------------------------------------------
// Usage notes:
//  - in_word_i carries kind, band, entry fields and position; out_word_o
//    carries status, the read entry, best band and removed count.
//  - Each band is a chain of LIST_DEPTH cells, band lists held side by side.
//  - Insert: all cells of the band compare rates at once and shift together
//    in S_INS; the result then goes through S_DONE to the output register.
//  - Get and remove: the chains rotate LIST_DEPTH steps (remove compacts as
//    it rotates), then the result goes through S_DONE as for insert.
//  - Best band: the rotation plus NUM_BANDS steps that shift per-band
//    winners towards band 0 where one comparator keeps the best.
//  - One word is worked at a time; rotation length sets the non-insert rate.
//  - in_ready_o is high only while idle; a new word may be taken while the
//    previous result still sits unread in the output register.
//  - If the receiver stalls, the finished result waits in its state until
//    the output register frees.
//  - Reset empties every list (lengths to zero); slot contents are left.
// ---------------------------------------------------------------------------
module per_band_rate_sorted_table #(
  parameter int NUM_BANDS  = 8,
  parameter int LIST_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pbrst_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pbrst_pkg::out_word_t out_word_o
);
  import pbrst_pkg::*;

  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CW = $clog2(NUM_BANDS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_ROT  = 3'd2;
  localparam logic [2:0] S_RED  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state_q, state_d;
  in_word_t      req_q;
  out_word_t     res_q, res_d, fin;
  out_word_t     out_q;
  logic          out_valid_q;
  logic [LW-1:0] step_q, step_d;
  logic [BW-1:0] red_q, red_d;
  logic [7:0]    cnt_q, cnt_d;
  logic          bb_found_q, bb_found_d;
  logic [31:0]   bb_rate_q, bb_rate_d;
  logic [BW-1:0] bb_band_q, bb_band_d;

  band_ctl_t     ctl;
  entry_t        new_e;
  entry_t        heads [NUM_BANDS];
  logic [LW-1:0] lens  [NUM_BANDS];
  logic          fulls [NUM_BANDS];
  logic          drops [NUM_BANDS];
  logic          bfs   [NUM_BANDS];
  logic [31:0]   brates[NUM_BANDS];

  logic          accept, out_free, bvalid, get_ok, upd;
  logic [BW-1:0] band_ix;
  logic [CW-1:0] pc;
  logic [8:0]    cnt_sum;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign band_ix  = BW'(req_q.band);
  assign bvalid   = (32'(req_q.band) < NUM_BANDS);
  assign get_ok   = bvalid && (32'(req_q.position) < 32'(lens[band_ix]));

  assign new_e.node_id   = req_q.node_id;
  assign new_e.dest_id   = req_q.dest_id;
  assign new_e.direction = req_q.direction;
  assign new_e.tx_power  = req_q.tx_power;
  assign new_e.rate      = req_q.rate;

  always_comb begin
    ctl.start = accept;
    ctl.ins   = (state_q == S_INS);
    ctl.rot   = (state_q == S_ROT) && (req_q.kind != KIND_REMOVE);
    ctl.rm    = (state_q == S_ROT) && (req_q.kind == KIND_REMOVE);
    ctl.best  = (state_q == S_ROT) && (req_q.kind == KIND_BEST);
    ctl.shift = (state_q == S_RED);
  end

  // bands: winners move towards band 0 during the reduction
  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
    logic        bf_nx;
    logic [31:0] br_nx;
    if (b < NUM_BANDS - 1) begin : g_nx
      assign bf_nx = bfs[b+1];
      assign br_nx = brates[b+1];
    end else begin : g_end
      assign bf_nx = 1'b0;
      assign br_nx = '0;
    end

    pbrst_band #(.LIST_DEPTH(LIST_DEPTH), .LW(LW)) u_band (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .sel_i        (bvalid && band_ix == BW'(b)),
      .step_i       (step_q),
      .new_i        (new_e),
      .node_i       (req_q.node_id),
      .bf_next_i    (bf_nx),
      .brate_next_i (br_nx),
      .head_o       (heads[b]),
      .len_o        (lens[b]),
      .full_o       (fulls[b]),
      .drop_o       (drops[b]),
      .bf_o         (bfs[b]),
      .brate_o      (brates[b])
    );
  end

  // entries dropped this step across all bands
  always_comb begin
    pc = '0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      pc = pc + CW'(drops[b]);
    end
  end

  assign cnt_sum = {1'b0, cnt_q} + 9'(pc);
  assign upd     = bfs[0] && (!bb_found_q || brates[0] > bb_rate_q);

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    step_d     = step_q;
    red_d      = red_q;
    cnt_d      = cnt_q;
    bb_found_d = bb_found_q;
    bb_rate_d  = bb_rate_q;
    bb_band_d  = bb_band_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d      = '0;
          step_d     = '0;
          red_d      = '0;
          cnt_d      = '0;
          bb_found_d = 1'b0;
          bb_rate_d  = '0;
          bb_band_d  = '0;
          state_d    = (in_word_i.kind == KIND_INSERT) ? S_INS : S_ROT;
        end
      end
      S_INS: begin
        res_d.status = (!bvalid || fulls[band_ix]) ? ST_FULL : ST_OK;
        state_d      = S_DONE;
      end
      S_ROT: begin
        cnt_d = cnt_sum[8] ? 8'hFF : cnt_sum[7:0];
        if (req_q.kind == KIND_GET && get_ok &&
            32'(step_q) == 32'(req_q.position)) begin
          res_d.out_node_id   = heads[band_ix].node_id;
          res_d.out_dest_id   = heads[band_ix].dest_id;
          res_d.out_direction = heads[band_ix].direction;
          res_d.out_tx_power  = heads[band_ix].tx_power;
          res_d.out_rate      = heads[band_ix].rate;
        end
        step_d = step_q + 1'b1;
        if (32'(step_q) == LIST_DEPTH - 1) begin
          if (req_q.kind == KIND_GET && !get_ok) begin
            res_d.status = ST_EMPTY;
          end
          state_d = (req_q.kind == KIND_BEST) ? S_RED : S_DONE;
        end
      end
      S_RED: begin
        if (upd) begin
          bb_found_d = 1'b1;
          bb_rate_d  = brates[0];
          bb_band_d  = red_q;
        end
        red_d = red_q + 1'b1;
        if (32'(red_q) == NUM_BANDS - 1) begin
          res_d.best_band = upd ? 3'(red_q) : 3'(bb_band_q);
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fin               = res_q;
    fin.removed_count = (req_q.kind == KIND_REMOVE) ? cnt_q : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      red_q       <= '0;
      bb_found_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      red_q      <= red_d;
      bb_found_q <= bb_found_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    cnt_q     <= cnt_d;
    bb_rate_q <= bb_rate_d;
    bb_band_q <= bb_band_d;
    if (accept) begin
      req_q <= in_word_i;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= fin;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_ins_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS |=> state_q == S_DONE)
    else $error("insert did not finish in one cycle");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROT |-> 32'(step_q) < LIST_DEPTH)
    else $error("rotation step out of range");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted word did not start work");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_q)
    else $error("finished result not presented");

endmodule
